// ===== design/ugb_pkg.sv =====
package ugb_pkg;

    localparam int ENT_W   = 6;
    localparam int COORD_W = 32;
    localparam int CS_W    = 31;
    localparam int DIM_W   = 6;
    localparam int BND_W   = 10;
    localparam int SEEN_W  = 64;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Z  = 3'd1,
        REG_CELL_EDGE = 3'd2,
        REG_COLUMNS   = 3'd3,
        REG_ROWS      = 3'd4
    } reg_idx_t;

endpackage

// ===== design/ugb_in_if.sv =====
interface ugb_in_if;
    import ugb_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [ENT_W-1:0]          entity;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_z;

    modport source (output valid, mode, entity, min_x, min_z, max_x, max_z, input ready);
    modport sink (input valid, mode, entity, min_x, min_z, max_x, max_z, output ready);
endinterface

// ===== design/ugb_out_if.sv =====
interface ugb_out_if;
    import ugb_pkg::*;
    logic             valid;
    logic             ready;
    logic [ENT_W-1:0] found_entity;
    logic             found;
    logic             overflow;
    logic             last;

    modport source (output valid, found_entity, found, overflow, last, input ready);
    modport sink (input valid, found_entity, found, overflow, last, output ready);
endinterface

// ===== design/ugb_ram.sv =====
module ugb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/uniform_grid_box_insert_query.sv =====
// Uniform-grid broadphase on the x/z plane, coordinates signed Q16.16.
// Requests arrive on req (valid/ready); mode 0 inserts an entity box into
// every covered cell, mode 1 queries a box. Results leave on rsp
// (valid/ready): an insert gives one result (entity echo, overflow flag),
// a query gives one result per distinct entity found, last on the final
// one, or a single result with found clear when nothing is hit.
// Registers origin_x, origin_z, cell edge length, columns, rows sit on the
// APB port at byte addresses 0, 4, 8, 12, 16; write them only while idle.
// One request is worked at a time. Four cell indices come from one shared
// restoring divider, then the walk reads and uses each covered cell's fill
// count (S_FRD, S_FUSE) and on a query each filled slot (S_SRD, S_SUSE),
// bound by the single read port of the fill and entry memories. The last
// result is loaded in S_DONE. A stalled rsp holds the walk when a
// new hit must leave while the previous one still waits.
// After reset the fill-count memory is cleared, one cell a cycle
// (MAX_COLUMNS*MAX_ROWS cells, 1024 by default); req.ready stays low
// meanwhile, configuration writes are taken throughout.
module uniform_grid_box_insert_query
    import ugb_pkg::*;
#(
    parameter int MAX_COLUMNS  = 32,
    parameter int MAX_ROWS     = 32,
    parameter int CELL_SLOTS   = 8,
    parameter int ENTITY_COUNT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    ugb_in_if.sink            req,
    ugb_out_if.source         rsp
);

    localparam int NUM_CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int NUM_ENT   = NUM_CELLS * CELL_SLOTS;
    localparam int CELL_AW   = $clog2(NUM_CELLS);
    localparam int ENT_AW    = $clog2(NUM_ENT);
    localparam int FILL_W    = $clog2(CELL_SLOTS + 1);
    localparam int VAL_W     = COORD_W + 3;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DLOAD = 10'b0000000100,
        S_DSTEP = 10'b0000001000,
        S_DEND  = 10'b0000010000,
        S_FRD   = 10'b0000100000,
        S_FUSE  = 10'b0001000000,
        S_SRD   = 10'b0010000000,
        S_SUSE  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    // clamp a signed quotient into a small signed bound
    function automatic logic signed [BND_W-1:0] clamp_bnd(
        input logic signed [VAL_W-1:0] v,
        input logic signed [BND_W-1:0] lo,
        input logic signed [BND_W-1:0] hi
    );
        logic signed [BND_W-1:0] res;
        if (v < VAL_W'(lo))
        begin
            res = lo;
        end
        else if (v > VAL_W'(hi))
        begin
            res = hi;
        end
        else
        begin
            res = v[BND_W-1:0];
        end
        return res;
    endfunction

    state_t state_reg, state_next;

    logic signed [COORD_W-1:0] origin_x_reg, origin_z_reg;
    logic [CS_W-1:0]           edge_len_reg;
    logic [DIM_W-1:0]          columns_reg, rows_reg;

    logic                      mode_reg;
    logic [ENT_W-1:0]          entity_reg;
    logic signed [COORD_W-1:0] min_x_reg, min_z_reg, max_x_reg, max_z_reg;

    logic [1:0]                div_idx_reg;
    logic [5:0]                div_cnt_reg;
    logic                      div_neg_reg;
    logic [COORD_W:0]          dq_reg;
    logic [CS_W-1:0]           rem_reg;

    logic signed [BND_W-1:0]   c0_reg, c1_reg, r0_reg, r1_reg;
    logic signed [BND_W-1:0]   cur_c_reg, cur_r_reg;
    logic [FILL_W-1:0]         slot_reg, fill_reg;
    logic                      ovf_reg;
    logic [SEEN_W-1:0]         seen_reg;
    logic                      pend_valid_reg;
    logic [ENT_W-1:0]          pend_ent_reg;
    logic [CELL_AW-1:0]        clr_cnt_reg;

    logic                      rsp_valid_reg;
    logic [ENT_W-1:0]          rsp_ent_reg;
    logic                      rsp_found_reg, rsp_ovf_reg, rsp_last_reg;

    // ---------------- configuration port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_z_reg <= '0;
            edge_len_reg <= CS_W'(65536);
            columns_reg  <= DIM_W'(32);
            rows_reg     <= DIM_W'(32);
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[APB_AW-1:2]))
                REG_ORIGIN_X:  origin_x_reg <= pwdata;
                REG_ORIGIN_Z:  origin_z_reg <= pwdata;
                REG_CELL_EDGE: edge_len_reg <= pwdata[CS_W-1:0];
                REG_COLUMNS:   columns_reg  <= pwdata[DIM_W-1:0];
                REG_ROWS:      rows_reg     <= pwdata[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
            REG_ORIGIN_X:  prdata = origin_x_reg;
            REG_ORIGIN_Z:  prdata = origin_z_reg;
            REG_CELL_EDGE: prdata = APB_DW'(edge_len_reg);
            REG_COLUMNS:   prdata = APB_DW'(columns_reg);
            REG_ROWS:      prdata = APB_DW'(rows_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- derived grid size ----------------
    logic [BND_W-1:0] nc, nr;
    logic [CS_W-1:0]  cs_eff;

    always_comb
    begin
        if (columns_reg == '0)
            nc = BND_W'(1);
        else if (BND_W'(columns_reg) > BND_W'(MAX_COLUMNS))
            nc = BND_W'(MAX_COLUMNS);
        else
            nc = BND_W'(columns_reg);
        if (rows_reg == '0)
            nr = BND_W'(1);
        else if (BND_W'(rows_reg) > BND_W'(MAX_ROWS))
            nr = BND_W'(MAX_ROWS);
        else
            nr = BND_W'(rows_reg);
        cs_eff = (edge_len_reg == '0) ? CS_W'(1) : edge_len_reg;
    end

    // ---------------- divider operand select ----------------
    logic signed [COORD_W-1:0] div_coord, div_org;
    logic signed [COORD_W:0]   div_diff;

    always_comb
    begin
        case (div_idx_reg)
            2'd0:    begin div_coord = min_x_reg; div_org = origin_x_reg; end
            2'd1:    begin div_coord = max_x_reg; div_org = origin_x_reg; end
            2'd2:    begin div_coord = min_z_reg; div_org = origin_z_reg; end
            default: begin div_coord = max_z_reg; div_org = origin_z_reg; end
        endcase
        div_diff = (COORD_W+1)'(div_coord) - (COORD_W+1)'(div_org);
    end

    // one restoring step
    logic [CS_W:0] rem_sh;
    logic          rem_ge;
    assign rem_sh = {rem_reg, dq_reg[COORD_W]};
    assign rem_ge = rem_sh >= {1'b0, cs_eff};

    // finish quotient: floor or ceil (less one for a query upper bound), then clamp
    logic                    is_upper, ceil_mode;
    logic signed [VAL_W-1:0] q_pos, q_adj, q_val;
    logic signed [BND_W-1:0] n_axis, lo_b, hi_b, bnd;

    always_comb
    begin
        is_upper  = div_idx_reg[0];
        ceil_mode = (mode_reg == MODE_QUERY) && is_upper;
        q_pos     = VAL_W'(dq_reg);
        q_adj     = q_pos + VAL_W'(rem_reg != '0);
        if (div_neg_reg)
            q_val = ceil_mode ? -q_pos : -q_adj;
        else
            q_val = ceil_mode ? q_adj : q_pos;
        n_axis = div_idx_reg[1] ? nr : nc;
        if (mode_reg == MODE_INSERT)
        begin
            lo_b = '0;
            hi_b = n_axis - BND_W'(1);
        end
        else if (is_upper)
        begin
            q_val = q_val - VAL_W'(1);
            lo_b  = -BND_W'(1);
            hi_b  = n_axis - BND_W'(1);
        end
        else
        begin
            lo_b = '0;
            hi_b = n_axis;
        end
        bnd = clamp_bnd(q_val, lo_b, hi_b);
    end

    // ---------------- memories ----------------
    logic [CELL_AW-1:0] cell_addr;
    logic [ENT_AW-1:0]  slot_raddr, slot_waddr;
    logic               fill_we, ent_we;
    logic [CELL_AW-1:0] fill_waddr;
    logic [FILL_W-1:0]  fill_wdata, fill_rdata;
    logic [ENT_W-1:0]   ent_rdata;

    assign cell_addr  = CELL_AW'(32'($unsigned(cur_r_reg)) * MAX_COLUMNS
                                 + 32'($unsigned(cur_c_reg)));
    assign slot_raddr = ENT_AW'(32'(cell_addr) * CELL_SLOTS + 32'(slot_reg));
    assign slot_waddr = ENT_AW'(32'(cell_addr) * CELL_SLOTS + 32'(fill_rdata));

    logic ins_room;
    assign ins_room = fill_rdata < FILL_W'(CELL_SLOTS);

    always_comb
    begin
        fill_we    = 1'b0;
        fill_waddr = cell_addr;
        fill_wdata = fill_rdata + FILL_W'(1);
        ent_we     = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            fill_we    = 1'b1;
            fill_waddr = clr_cnt_reg;
            fill_wdata = '0;
        end
        else if (state_reg == S_FUSE && mode_reg == MODE_INSERT && ins_room)
        begin
            fill_we = 1'b1;
            ent_we  = 1'b1;
        end
    end

    ugb_ram #(.WIDTH(FILL_W), .DEPTH(NUM_CELLS)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (cell_addr),
        .rdata (fill_rdata)
    );

    ugb_ram #(.WIDTH(ENT_W), .DEPTH(NUM_ENT)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (slot_waddr),
        .wdata (entity_reg),
        .raddr (slot_raddr),
        .rdata (ent_rdata)
    );

    // ---------------- handshakes ----------------
    logic req_fire, can_load, last_cell, hit, last_slot, rsp_load;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign can_load  = !rsp_valid_reg || rsp.ready;
    assign last_cell = (cur_c_reg >= c1_reg) && (cur_r_reg >= r1_reg);
    assign hit       = !seen_reg[ent_rdata];
    assign last_slot = (slot_reg + FILL_W'(1)) >= fill_reg;
    assign rsp_load  = ((state_reg == S_SUSE) && hit && pend_valid_reg && can_load)
                       || ((state_reg == S_DONE) && can_load);

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.found_entity = rsp_ent_reg;
    assign rsp.found        = rsp_found_reg;
    assign rsp.overflow     = rsp_ovf_reg;
    assign rsp.last         = rsp_last_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_cnt_reg == CELL_AW'(NUM_CELLS - 1)) state_next = S_IDLE;
            S_IDLE:  if (req_fire) state_next = S_DLOAD;
            S_DLOAD: state_next = S_DSTEP;
            S_DSTEP: if (div_cnt_reg == 6'd32) state_next = S_DEND;
            S_DEND:
            begin
                if (div_idx_reg != 2'd3)
                    state_next = S_DLOAD;
                else if ((c0_reg > c1_reg) || (r0_reg > bnd)
                         || (mode_reg == MODE_INSERT
                             && 32'(entity_reg) >= ENTITY_COUNT))
                    state_next = S_DONE;
                else
                    state_next = S_FRD;
            end
            S_FRD:   state_next = S_FUSE;
            S_FUSE:
            begin
                if (mode_reg == MODE_QUERY && fill_rdata != '0)
                    state_next = S_SRD;
                else if (last_cell)
                    state_next = S_DONE;
                else
                    state_next = S_FRD;
            end
            S_SRD:   state_next = S_SUSE;
            S_SUSE:
            begin
                if (!(hit && pend_valid_reg && !can_load))
                begin
                    if (!last_slot)
                        state_next = S_SRD;
                    else if (last_cell)
                        state_next = S_DONE;
                    else
                        state_next = S_FRD;
                end
            end
            S_DONE:  if (can_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            seen_reg       <= '0;
            div_idx_reg    <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: clr_cnt_reg <= clr_cnt_reg + CELL_AW'(1);
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        seen_reg       <= '0;
                        pend_valid_reg <= 1'b0;
                        div_idx_reg    <= '0;
                    end
                end
                S_DLOAD: div_cnt_reg <= '0;
                S_DSTEP: div_cnt_reg <= div_cnt_reg + 6'd1;
                S_DEND:  div_idx_reg <= div_idx_reg + 2'd1;
                S_SUSE:
                begin
                    if (hit && !(pend_valid_reg && !can_load))
                    begin
                        seen_reg[ent_rdata] <= 1'b1;
                        pend_valid_reg      <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // hold request payload, divider and walk data
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                mode_reg   <= req.mode;
                entity_reg <= req.entity;
                min_x_reg  <= req.min_x;
                min_z_reg  <= req.min_z;
                max_x_reg  <= req.max_x;
                max_z_reg  <= req.max_z;
                ovf_reg    <= 1'b0;
            end
            S_DLOAD:
            begin
                div_neg_reg <= div_diff[COORD_W];
                dq_reg      <= div_diff[COORD_W] ? (COORD_W+1)'(-div_diff)
                                                 : (COORD_W+1)'(div_diff);
                rem_reg     <= '0;
            end
            S_DSTEP:
            begin
                rem_reg <= rem_ge ? CS_W'(rem_sh - {1'b0, cs_eff}) : CS_W'(rem_sh);
                dq_reg  <= {dq_reg[COORD_W-1:0], rem_ge};
            end
            S_DEND:
            begin
                case (div_idx_reg)
                    2'd0:    c0_reg <= bnd;
                    2'd1:    c1_reg <= bnd;
                    2'd2:    r0_reg <= bnd;
                    default: r1_reg <= bnd;
                endcase
                cur_c_reg <= c0_reg;
                cur_r_reg <= r0_reg;
            end
            S_FUSE:
            begin
                fill_reg <= fill_rdata;
                slot_reg <= '0;
                if (mode_reg == MODE_INSERT && !ins_room)
                    ovf_reg <= 1'b1;
                if (!(mode_reg == MODE_QUERY && fill_rdata != '0) && !last_cell)
                begin
                    if (cur_c_reg < c1_reg)
                        cur_c_reg <= cur_c_reg + BND_W'(1);
                    else
                    begin
                        cur_c_reg <= c0_reg;
                        cur_r_reg <= cur_r_reg + BND_W'(1);
                    end
                end
            end
            S_SUSE:
            begin
                if (!(hit && pend_valid_reg && !can_load))
                begin
                    slot_reg <= slot_reg + FILL_W'(1);
                    if (hit)
                    begin
                        pend_ent_reg <= ent_rdata;
                        if (pend_valid_reg)
                        begin
                            rsp_ent_reg   <= pend_ent_reg;
                            rsp_found_reg <= 1'b1;
                            rsp_ovf_reg   <= 1'b0;
                            rsp_last_reg  <= 1'b0;
                        end
                    end
                    if (last_slot && !last_cell)
                    begin
                        if (cur_c_reg < c1_reg)
                            cur_c_reg <= cur_c_reg + BND_W'(1);
                        else
                        begin
                            cur_c_reg <= c0_reg;
                            cur_r_reg <= cur_r_reg + BND_W'(1);
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    rsp_last_reg <= 1'b1;
                    if (mode_reg == MODE_INSERT)
                    begin
                        rsp_ent_reg   <= entity_reg;
                        rsp_found_reg <= 1'b0;
                        rsp_ovf_reg   <= ovf_reg;
                    end
                    else
                    begin
                        rsp_ent_reg   <= pend_valid_reg ? pend_ent_reg : '0;
                        rsp_found_reg <= pend_valid_reg;
                        rsp_ovf_reg   <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
